// ----- src/qcrm_pkg.sv -----
// ----------------------------------------------------------------------------
// qcrm_pkg
// Shared constants, types and state codes of the quad corner running median.
// ----------------------------------------------------------------------------
package qcrm_pkg;

  localparam int NUM_CH             = 8;
  localparam int MAX_WINDOW_DEF     = 16;
  localparam int COORD_WIDTH_DEF    = 16;
  localparam int WIN_WIDTH          = 5;
  localparam logic [WIN_WIDTH-1:0] WINDOW_RESET = 5'd5;

  // channel order of the eight coordinates
  localparam int CH_TL_X = 0;
  localparam int CH_TL_Y = 1;
  localparam int CH_TR_X = 2;
  localparam int CH_TR_Y = 3;
  localparam int CH_BR_X = 4;
  localparam int CH_BR_Y = 5;
  localparam int CH_BL_X = 6;
  localparam int CH_BL_Y = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_SELECT
  } state_t;

  typedef struct packed {
    logic shift;  // take a new quad, load the circulating copy, clear ranks
    logic step;   // compare against the circulating copy, then pass it on
  } cell_ctrl_t;

endpackage

// ----- src/qcrm_if.sv -----
// ----------------------------------------------------------------------------
// qcrm channel interfaces
// Valid/ready channels for input quads, median results and the window register.
// ----------------------------------------------------------------------------
interface qcrm_quad_if import qcrm_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] top_left_x;
  logic signed [COORD_WIDTH-1:0] top_left_y;
  logic signed [COORD_WIDTH-1:0] top_right_x;
  logic signed [COORD_WIDTH-1:0] top_right_y;
  logic signed [COORD_WIDTH-1:0] bottom_right_x;
  logic signed [COORD_WIDTH-1:0] bottom_right_y;
  logic signed [COORD_WIDTH-1:0] bottom_left_x;
  logic signed [COORD_WIDTH-1:0] bottom_left_y;

  modport source (
    output valid, top_left_x, top_left_y, top_right_x, top_right_y,
           bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y,
    input  ready
  );
  modport sink (
    input  valid, top_left_x, top_left_y, top_right_x, top_right_y,
           bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y,
    output ready
  );
endinterface

interface qcrm_med_if import qcrm_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] med_top_left_x;
  logic signed [COORD_WIDTH-1:0] med_top_left_y;
  logic signed [COORD_WIDTH-1:0] med_top_right_x;
  logic signed [COORD_WIDTH-1:0] med_top_right_y;
  logic signed [COORD_WIDTH-1:0] med_bottom_right_x;
  logic signed [COORD_WIDTH-1:0] med_bottom_right_y;
  logic signed [COORD_WIDTH-1:0] med_bottom_left_x;
  logic signed [COORD_WIDTH-1:0] med_bottom_left_y;

  modport source (
    output valid, med_top_left_x, med_top_left_y, med_top_right_x, med_top_right_y,
           med_bottom_right_x, med_bottom_right_y, med_bottom_left_x,
           med_bottom_left_y,
    input  ready
  );
  modport sink (
    input  valid, med_top_left_x, med_top_left_y, med_top_right_x, med_top_right_y,
           med_bottom_right_x, med_bottom_right_y, med_bottom_left_x,
           med_bottom_left_y,
    output ready
  );
endinterface

interface qcrm_cfg_if import qcrm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WIN_WIDTH-1:0] window_size;

  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface

// ----- src/quad_corner_running_median.sv -----
// ----------------------------------------------------------------------------
// quad_corner_running_median
// Running median of each of the eight corner coordinates over the newest
// window_size quads, held in a chain of history cells.
// ----------------------------------------------------------------------------
//  channel  role    carries
//  quad     sink    eight corner coordinates of one quad
//  med      source  eight median coordinates, one result per quad
//  cfg      sink    window_size register write
//
//  an item is handled in order: the quad is taken and the ring loaded, the
//  ranking copy circles the chain of cells, and the middle values are picked
//  into the output register.
//  the result waits there; the next quad is taken while it waits, but the
//  select step holds until the output register is free.
//  synchronous reset clears control, fill count and window (to 5); history
//  cells carry no reset and are only read once written.
// ----------------------------------------------------------------------------
module quad_corner_running_median import qcrm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  qcrm_quad_if.sink  quad,
  qcrm_med_if.source med,
  qcrm_cfg_if.sink   cfg
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(MAX_WINDOW - 1);

  state_t               state;
  state_t               state_next;
  logic [WIN_WIDTH-1:0] window_size;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        win;
  logic [CW:0]          fill_inc;
  logic [CW-1:0]        n_next;
  logic [IW-1:0]        step_cnt;
  cell_ctrl_t           ctrl;
  logic                 take;
  logic                 load_out;
  logic                 med_valid;

  logic signed [COORD_WIDTH-1:0] in_quad  [NUM_CH];
  logic signed [COORD_WIDTH-1:0] hist_w   [MAX_WINDOW+1][NUM_CH];
  logic signed [COORD_WIDTH-1:0] hist_all [MAX_WINDOW][NUM_CH];
  logic signed [COORD_WIDTH-1:0] circ_w   [MAX_WINDOW][NUM_CH];
  logic [IW-1:0]                 tag_w    [MAX_WINDOW];
  logic                          act_w    [MAX_WINDOW];
  logic [CW-1:0]                 rank_all [MAX_WINDOW][NUM_CH];
  logic signed [COORD_WIDTH-1:0] sel_med  [NUM_CH];
  logic signed [COORD_WIDTH-1:0] med_q    [NUM_CH];

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg.valid && cfg.ready) begin
      window_size <= cfg.window_size;
    end
  end

  // effective window: zero acts as one, clamped to the chain length
  always_comb begin
    if (32'(window_size) > 32'(MAX_WINDOW)) begin
      win = CW'(MAX_WINDOW);
    end else if (window_size == '0) begin
      win = CW'(1);
    end else begin
      win = CW'(window_size);
    end
    fill_inc = {1'b0, fill} + (CW+1)'(1);
    n_next   = (fill_inc > {1'b0, win}) ? win : fill_inc[CW-1:0];
  end

  assign in_quad[CH_TL_X] = quad.top_left_x;
  assign in_quad[CH_TL_Y] = quad.top_left_y;
  assign in_quad[CH_TR_X] = quad.top_right_x;
  assign in_quad[CH_TR_Y] = quad.top_right_y;
  assign in_quad[CH_BR_X] = quad.bottom_right_x;
  assign in_quad[CH_BR_Y] = quad.bottom_right_y;
  assign in_quad[CH_BL_X] = quad.bottom_left_x;
  assign in_quad[CH_BL_Y] = quad.bottom_left_y;

  assign hist_w[0] = in_quad;

  // sequencer
  always_comb begin
    state_next = state;
    quad.ready = 1'b0;
    take       = 1'b0;
    load_out   = 1'b0;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        quad.ready = 1'b1;
        if (quad.valid) begin
          take       = 1'b1;
          ctrl.shift = 1'b1;
          state_next = ST_RANK;
        end
      end
      ST_RANK: begin
        ctrl.step = 1'b1;
        if (step_cnt == LAST_STEP) state_next = ST_SELECT;
      end
      ST_SELECT: begin
        if (!med_valid || med.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      step_cnt <= '0;
    end else begin
      if (take) fill <= n_next;
      if (ctrl.shift) begin
        step_cnt <= '0;
      end else if (ctrl.step) begin
        step_cnt <= step_cnt + IW'(1);
      end
    end
  end

  // chain of history cells, newest in cell 0; ranking copy circles the ring
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    localparam int PREV = (i + MAX_WINDOW - 1) % MAX_WINDOW;
    qcrm_cell #(
      .MAX_WINDOW  (MAX_WINDOW),
      .COORD_WIDTH (COORD_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .n            (n_next),
      .hist_in      (hist_w[i]),
      .hist_out     (hist_w[i+1]),
      .circ_in      (circ_w[PREV]),
      .circ_tag_in  (tag_w[PREV]),
      .circ_act_in  (act_w[PREV]),
      .circ_out     (circ_w[i]),
      .circ_tag_out (tag_w[i]),
      .circ_act_out (act_w[i]),
      .rank         (rank_all[i])
    );
    assign hist_all[i] = hist_w[i+1];
  end

  qcrm_select #(
    .MAX_WINDOW  (MAX_WINDOW),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_select (
    .n    (fill),
    .hist (hist_all),
    .rank (rank_all),
    .med  (sel_med)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      med_valid <= 1'b0;
    end else if (load_out) begin
      med_valid <= 1'b1;
    end else if (med.ready) begin
      med_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) med_q <= sel_med;
  end

  assign med.valid              = med_valid;
  assign med.med_top_left_x     = med_q[CH_TL_X];
  assign med.med_top_left_y     = med_q[CH_TL_Y];
  assign med.med_top_right_x    = med_q[CH_TR_X];
  assign med.med_top_right_y    = med_q[CH_TR_Y];
  assign med.med_bottom_right_x = med_q[CH_BR_X];
  assign med.med_bottom_right_y = med_q[CH_BR_Y];
  assign med.med_bottom_left_x  = med_q[CH_BL_X];
  assign med.med_bottom_left_y  = med_q[CH_BL_Y];

endmodule

// ----- src/qcrm_cell.sv -----
// ----------------------------------------------------------------------------
// qcrm_cell
// One history slot of the chain: holds a quad, passes it on to the older
// neighbour on each new transfer, and ranks its eight values against a copy
// of the history that circulates round the ring one slot per cycle.
// ----------------------------------------------------------------------------
module qcrm_cell import qcrm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int IDX         = 0,
  localparam int CW = $clog2(MAX_WINDOW + 1),
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic [CW-1:0]                 n,
  input  logic signed [COORD_WIDTH-1:0] hist_in  [NUM_CH],
  output logic signed [COORD_WIDTH-1:0] hist_out [NUM_CH],
  input  logic signed [COORD_WIDTH-1:0] circ_in  [NUM_CH],
  input  logic [IW-1:0]                 circ_tag_in,
  input  logic                          circ_act_in,
  output logic signed [COORD_WIDTH-1:0] circ_out [NUM_CH],
  output logic [IW-1:0]                 circ_tag_out,
  output logic                          circ_act_out,
  output logic [CW-1:0]                 rank     [NUM_CH]
);

  localparam logic [IW-1:0] MY_TAG = IW'(IDX);

  logic signed [COORD_WIDTH-1:0] hist     [NUM_CH];
  logic signed [COORD_WIDTH-1:0] circ_val [NUM_CH];
  logic [IW-1:0]                 circ_tag;
  logic                          circ_act;
  logic                          less     [NUM_CH];

  // ties broken by slot so every active value gets a distinct rank
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      less[c] = circ_act && ((circ_val[c] < hist[c]) ||
                             ((circ_val[c] == hist[c]) && (circ_tag < MY_TAG)));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int c = 0; c < NUM_CH; c++) begin
        hist[c]     <= hist_in[c];
        circ_val[c] <= hist_in[c];
        rank[c]     <= '0;
      end
      circ_tag <= MY_TAG;
      circ_act <= (IDX < int'(n));
    end else if (ctrl.step) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rank[c]     <= rank[c] + CW'(less[c]);
        circ_val[c] <= circ_in[c];
      end
      circ_tag <= circ_tag_in;
      circ_act <= circ_act_in;
    end
  end

  assign hist_out     = hist;
  assign circ_out     = circ_val;
  assign circ_tag_out = circ_tag;
  assign circ_act_out = circ_act;

endmodule

// ----- src/qcrm_select.sv -----
// ----------------------------------------------------------------------------
// qcrm_select
// Picks the one or two middle-ranked values of each channel from the ranked
// cells and forms their mean, truncated toward zero.
// ----------------------------------------------------------------------------
module qcrm_select import qcrm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WINDOW + 1)
) (
  input  logic [CW-1:0]                 n,
  input  logic signed [COORD_WIDTH-1:0] hist [MAX_WINDOW][NUM_CH],
  input  logic [CW-1:0]                 rank [MAX_WINDOW][NUM_CH],
  output logic signed [COORD_WIDTH-1:0] med  [NUM_CH]
);

  logic [CW-1:0]          r_lo;
  logic [CW-1:0]          r_hi;
  logic [COORD_WIDTH-1:0] lo  [NUM_CH];
  logic [COORD_WIDTH-1:0] hi  [NUM_CH];
  logic signed [COORD_WIDTH:0] sum  [NUM_CH];
  logic signed [COORD_WIDTH:0] rnd  [NUM_CH];

  // odd count: both picks are the middle rank
  assign r_lo = (n - CW'(1)) >> 1;
  assign r_hi = n >> 1;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      lo[c] = '0;
      hi[c] = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        if ((i < int'(n)) && (rank[i][c] == r_lo)) lo[c] = lo[c] | hist[i][c];
        if ((i < int'(n)) && (rank[i][c] == r_hi)) hi[c] = hi[c] | hist[i][c];
      end
      sum[c] = $signed({lo[c][COORD_WIDTH-1], lo[c]}) +
               $signed({hi[c][COORD_WIDTH-1], hi[c]});
      // add one to negative sums so the halving truncates toward zero
      rnd[c] = sum[c] + $signed({{COORD_WIDTH{1'b0}}, sum[c][COORD_WIDTH]});
      med[c] = $signed(rnd[c][COORD_WIDTH:1]);
    end
  end

endmodule

// ----- src/qcrm_checker.sv -----
// ----------------------------------------------------------------------------
// qcrm_checker
// Port-level checks of the quad corner running median, bound to the top level.
// ----------------------------------------------------------------------------
module qcrm_checker import qcrm_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   quad_valid,
  input logic                   quad_ready,
  input logic                   med_valid,
  input logic                   med_ready,
  input logic [COORD_WIDTH-1:0] med_tl_x,
  input logic [COORD_WIDTH-1:0] med_bl_y
);

  // a held result keeps its payload (top-left x and bottom-left y are checked)
  a_med_hold: assert property (@(posedge clk) disable iff (rst)
    med_valid && !med_ready |=> med_valid && $stable(med_tl_x) && $stable(med_bl_y))
    else $error("med result changed while stalled");

  // one quad at a time: ranking starts right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    quad_valid && quad_ready |=> !quad_ready)
    else $error("quad taken while a previous one is being ranked");

  // a result never follows its quad in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(med_valid) |-> !$past(quad_valid && quad_ready))
    else $error("result raised straight after an input transfer");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !med_valid)
    else $error("result valid straight after reset");

endmodule

bind quad_corner_running_median qcrm_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_qcrm_checker (
  .clk        (clk),
  .rst        (rst),
  .quad_valid (quad.valid),
  .quad_ready (quad.ready),
  .med_valid  (med.valid),
  .med_ready  (med.ready),
  .med_tl_x   (med.med_top_left_x),
  .med_bl_y   (med.med_bottom_left_y)
);
